### rtl/core/assert_macros.svh
// Assertion macros shared by the allocator RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);
`define ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define ASSERT_CLK(label, prop, msg)
`define ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

### rtl/core/ffha_pkg.sv
// Types, constants and helpers of the first-fit hole allocator
package ffha_pkg;

    localparam int MAX_HOLES_DEF = 128;
    localparam int ALIGN_BYTES   = 8;
    localparam int HEADER_BYTES  = 8;
    localparam int ADDR_W        = 64;
    localparam int LEN_W         = 48;
    localparam int GRANT_W       = 28;
    localparam logic [LEN_W-1:0] SIZE_LIMIT = LEN_W'(128 * 1024 * 1024);

    typedef enum logic [1:0] {
        REQ_ALLOC = 2'd0,
        REQ_FREE  = 2'd1,
        REQ_ADD   = 2'd2,
        REQ_NONE  = 2'd3
    } t_req_type;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_TOO_BIG = 2'd1,
        ST_NO_FIT  = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        W_ALLOC,
        W_MERGE,
        W_CHAIN,
        W_MOVE,
        W_TOP,
        W_NEW
    } t_wsel;

    typedef enum logic [1:0] {
        R_IDX,
        R_NEXT,
        R_PREV
    } t_rsel;

    typedef enum logic [1:0] {
        I_HOLD,
        I_INC,
        I_DEC,
        I_CNT
    } t_idx_op;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [ADDR_W-1:0]  req_addr;
        logic [LEN_W-1:0]   req_size;
    } t_req;

    typedef struct packed {
        logic [1:0]         status;
        logic [ADDR_W-1:0]  block_addr;
        logic [GRANT_W-1:0] granted_size;
    } t_rsp;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [LEN_W-1:0]  length;
    } t_entry;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        t_rsel   rsel;
        logic    wr_en;
        t_wsel   wsel;
        t_idx_op idx_op;
        logic    pos_save;
        logic    cnt_inc;
        logic    cnt_dec;
        logic    res_set;
        t_status res_code;
        logic    res_grant;
    } t_cmd;

    typedef struct packed {
        t_req_type req_type;
        logic      too_big;
        logic      len_zero;
        logic      idx_lt_cnt;
        logic      idx1_lt_cnt;
        logic      idx_gt_pos;
        logic      fit;
        logic      exact;
        logic      end_eq;
        logic      start_gt;
        logic      top_eq;
        logic      chain_eq;
        logic      full;
    } t_sts;

    function automatic logic [LEN_W-1:0] sat_add(input logic [LEN_W-1:0] a,
                                                 input logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? {LEN_W{1'b1}} : s[LEN_W-1:0];
    endfunction

endpackage

### rtl/core/first_fit_hole_allocator.sv
// First-fit hole allocator with coalescing: top level
// An allocate scans the holes in order and moves later holes down when a hole is used up;
// a free or add scans the holes and moves later holes up to insert a new one, with one
// table access per step.
// One request at a time; busy stays high until the result word strobes on o_done.
// Reset clears the hole count and region offset; table contents are left as they are.
module first_fit_hole_allocator #(
    parameter int MAX_HOLES = ffha_pkg::MAX_HOLES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        start,
    output logic                        busy,
    input  ffha_pkg::t_req              i_req,
    output logic                        o_done,
    output ffha_pkg::t_rsp              o_rsp,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [ffha_pkg::ADDR_W-1:0] i_cfg_data
);
    ffha_pkg::t_cmd w_cmd;
    ffha_pkg::t_sts w_sts;
    logic           w_busy;

    assign busy        = w_busy;
    assign o_cfg_ready = !w_busy;

    ffha_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd),
        .o_busy  (w_busy),
        .o_done  (o_done)
    );

    ffha_dp #(
        .MAX_HOLES (MAX_HOLES)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_valid && !w_busy),
        .i_cfg_data (i_cfg_data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_rsp      (o_rsp)
    );
endmodule

### rtl/core/ffha_ram.sv
// Generic single-write, single-read RAM with registered read data
module ffha_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

### rtl/core/ffha_dp.sv
// Datapath of the hole allocator: hole table, index and count, compare and merge logic
`include "assert_macros.svh"
module ffha_dp #(
    parameter int MAX_HOLES = ffha_pkg::MAX_HOLES_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ffha_pkg::t_req                i_req,
    input  logic                          i_cfg_we,
    input  logic [ffha_pkg::ADDR_W-1:0]   i_cfg_data,
    input  ffha_pkg::t_cmd                i_cmd,
    output ffha_pkg::t_sts                o_sts,
    output ffha_pkg::t_rsp                o_rsp
);
    localparam int AW = $clog2(MAX_HOLES);
    localparam int CW = $clog2(MAX_HOLES + 1);
    localparam int LW = ffha_pkg::LEN_W;
    localparam int XW = ffha_pkg::ADDR_W;
    localparam int GW = ffha_pkg::GRANT_W;

    ffha_pkg::t_req_type r_type;
    logic [XW-1:0]       r_start;
    logic [LW-1:0]       r_len;
    logic [GW-1:0]       r_need;
    logic                r_too_big;
    logic [XW-1:0]       r_top;
    logic [XW-1:0]       r_estart;
    logic [LW-1:0]       r_mlen;
    logic [XW-1:0]       r_offset;
    logic [CW-1:0]       r_idx;
    logic [CW-1:0]       r_pos;
    logic [CW-1:0]       r_cnt;
    logic [1:0]          r_status;
    logic [XW-1:0]       r_block;
    logic [GW-1:0]       r_granted;

    logic [CW-1:0]       w_idx1;
    logic [CW-1:0]       w_idxm;
    logic [CW-1:0]       w_raddr;
    logic [GW-1:0]       w_need;
    logic [LW-1:0]       w_mlen_new;
    logic [LW-1:0]       w_chain_len;
    ffha_pkg::t_entry    w_rdata;
    ffha_pkg::t_entry    w_wdata;

    assign w_idx1 = r_idx + CW'(1);
    assign w_idxm = r_idx - CW'(1);
    assign w_need = (i_req.req_size[GW-1:0] + GW'(ffha_pkg::ALIGN_BYTES + ffha_pkg::HEADER_BYTES))
                    & ~GW'(ffha_pkg::ALIGN_BYTES - 1);
    assign w_mlen_new  = ffha_pkg::sat_add(w_rdata.length, r_len);
    assign w_chain_len = ffha_pkg::sat_add(r_mlen, w_rdata.length);

    always_comb begin
        case (i_cmd.rsel)
            ffha_pkg::R_IDX:  w_raddr = r_idx;
            ffha_pkg::R_NEXT: w_raddr = w_idx1;
            ffha_pkg::R_PREV: w_raddr = w_idxm;
            default:          w_raddr = r_idx;
        endcase
    end

    always_comb begin
        w_wdata = w_rdata;
        case (i_cmd.wsel)
            ffha_pkg::W_ALLOC: begin
                w_wdata.start  = w_rdata.start + XW'(r_need);
                w_wdata.length = w_rdata.length - LW'(r_need);
            end
            ffha_pkg::W_MERGE: begin
                w_wdata.start  = w_rdata.start;
                w_wdata.length = w_mlen_new;
            end
            ffha_pkg::W_CHAIN: begin
                w_wdata.start  = r_estart;
                w_wdata.length = w_chain_len;
            end
            ffha_pkg::W_MOVE: w_wdata = w_rdata;
            ffha_pkg::W_TOP: begin
                w_wdata.start  = r_start;
                w_wdata.length = w_mlen_new;
            end
            ffha_pkg::W_NEW: begin
                w_wdata.start  = r_start;
                w_wdata.length = r_len;
            end
            default: w_wdata = w_rdata;
        endcase
    end

    ffha_ram #(
        .WIDTH ($bits(ffha_pkg::t_entry)),
        .DEPTH (MAX_HOLES)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (r_idx[AW-1:0]),
        .i_wdata (w_wdata),
        .i_re    (i_cmd.rd_en),
        .i_raddr (w_raddr[AW-1:0]),
        .o_rdata (w_rdata)
    );

    always_comb begin
        o_sts.req_type    = r_type;
        o_sts.too_big     = r_too_big;
        o_sts.len_zero    = (r_len == '0);
        o_sts.idx_lt_cnt  = (r_idx < r_cnt);
        o_sts.idx1_lt_cnt = (w_idx1 < r_cnt);
        o_sts.idx_gt_pos  = (r_idx > r_pos);
        o_sts.fit         = (w_rdata.length >= LW'(r_need));
        o_sts.exact       = (w_rdata.length == LW'(r_need));
        o_sts.end_eq      = ((w_rdata.start + XW'(w_rdata.length)) == r_start);
        o_sts.start_gt    = (w_rdata.start > r_start);
        o_sts.top_eq      = (r_top == w_rdata.start);
        o_sts.chain_eq    = ((r_estart + XW'(r_mlen)) == w_rdata.start);
        o_sts.full        = (r_cnt == CW'(MAX_HOLES));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx    <= '0;
            r_cnt    <= '0;
            r_offset <= '0;
            r_type   <= ffha_pkg::REQ_NONE;
        end else begin
            if (i_cfg_we) begin
                r_offset <= i_cfg_data;
            end
            if (i_cmd.load) begin
                r_type <= ffha_pkg::t_req_type'(i_req.req_type);
                r_idx  <= '0;
            end else begin
                case (i_cmd.idx_op)
                    ffha_pkg::I_HOLD: r_idx <= r_idx;
                    ffha_pkg::I_INC:  r_idx <= w_idx1;
                    ffha_pkg::I_DEC:  r_idx <= w_idxm;
                    ffha_pkg::I_CNT:  r_idx <= r_cnt;
                    default:          r_idx <= r_idx;
                endcase
            end
            if (i_cmd.cnt_inc) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (i_cmd.cnt_dec) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= r_start + XW'(r_len);
        if (i_cmd.load) begin
            r_len     <= i_req.req_size;
            r_need    <= w_need;
            r_too_big <= (i_req.req_size > ffha_pkg::SIZE_LIMIT);
            if (i_req.req_type == ffha_pkg::REQ_FREE) begin
                r_start <= i_req.req_addr - XW'(ffha_pkg::HEADER_BYTES);
            end else begin
                r_start <= i_req.req_addr + r_offset;
            end
        end
        if (i_cmd.pos_save) begin
            r_pos <= r_idx;
        end
        if (i_cmd.wr_en && (i_cmd.wsel == ffha_pkg::W_MERGE)) begin
            r_estart <= w_rdata.start;
            r_mlen   <= w_mlen_new;
        end
        if (i_cmd.res_set) begin
            r_status  <= i_cmd.res_code;
            r_block   <= i_cmd.res_grant ? w_rdata.start : '0;
            r_granted <= i_cmd.res_grant ? r_need : '0;
        end
    end

    assign o_rsp.status       = r_status;
    assign o_rsp.block_addr   = r_block;
    assign o_rsp.granted_size = r_granted;

    `ASSERT_CLK(a_cnt_bound, r_cnt <= CW'(MAX_HOLES), "hole count beyond table size")
    `ASSERT_CLK(a_idx_bound, r_idx <= r_cnt, "index beyond hole count")
    `ASSERT_NEXT(a_cnt_step, i_cmd.cnt_inc, r_cnt == $past(r_cnt) + CW'(1),
                 "hole count did not advance")
endmodule

### rtl/core/ffha_ctrl.sv
// Controller of the hole allocator: sequences scans, moves and result updates
`include "assert_macros.svh"
module ffha_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  ffha_pkg::t_sts i_sts,
    output ffha_pkg::t_cmd o_cmd,
    output logic           o_busy,
    output logic           o_done
);
    typedef enum logic [3:0] {
        S_IDLE,
        S_PREP,
        S_A_RD,
        S_A_CK,
        S_R_RD,
        S_R_CK,
        S_I_RD,
        S_I_CK,
        S_M_RD,
        S_M_CK,
        S_POST,
        S_U_RD,
        S_U_CK
    } t_state;

    t_state         r_state;
    t_state         n_state;
    logic           r_done;
    logic           n_done;
    ffha_pkg::t_cmd w_cmd;

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        w_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                case (i_sts.req_type)
                    ffha_pkg::REQ_ALLOC: begin
                        if (i_sts.too_big) begin
                            w_cmd.res_set  = 1'b1;
                            w_cmd.res_code = ffha_pkg::ST_TOO_BIG;
                            n_done         = 1'b1;
                            n_state        = S_IDLE;
                        end else begin
                            n_state = S_A_RD;
                        end
                    end
                    ffha_pkg::REQ_FREE, ffha_pkg::REQ_ADD: begin
                        if (i_sts.len_zero) begin
                            w_cmd.res_set = 1'b1;
                            n_done        = 1'b1;
                            n_state       = S_IDLE;
                        end else begin
                            n_state = S_I_RD;
                        end
                    end
                    default: begin
                        w_cmd.res_set = 1'b1;
                        n_done        = 1'b1;
                        n_state       = S_IDLE;
                    end
                endcase
            end
            S_A_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    w_cmd.rd_en = 1'b1;
                    n_state     = S_A_CK;
                end else begin
                    w_cmd.res_set  = 1'b1;
                    w_cmd.res_code = ffha_pkg::ST_NO_FIT;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_A_CK: begin
                if (i_sts.fit) begin
                    w_cmd.res_set   = 1'b1;
                    w_cmd.res_grant = 1'b1;
                    if (i_sts.exact) begin
                        n_state = S_R_RD;
                    end else begin
                        w_cmd.wr_en = 1'b1;
                        w_cmd.wsel  = ffha_pkg::W_ALLOC;
                        n_done      = 1'b1;
                        n_state     = S_IDLE;
                    end
                end else begin
                    w_cmd.idx_op = ffha_pkg::I_INC;
                    n_state      = S_A_RD;
                end
            end
            S_R_RD: begin
                if (i_sts.idx1_lt_cnt) begin
                    w_cmd.rd_en = 1'b1;
                    w_cmd.rsel  = ffha_pkg::R_NEXT;
                    n_state     = S_R_CK;
                end else begin
                    w_cmd.cnt_dec = 1'b1;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_R_CK: begin
                w_cmd.wr_en  = 1'b1;
                w_cmd.wsel   = ffha_pkg::W_MOVE;
                w_cmd.idx_op = ffha_pkg::I_INC;
                n_state      = S_R_RD;
            end
            S_I_RD: begin
                if (i_sts.idx_lt_cnt) begin
                    w_cmd.rd_en = 1'b1;
                    n_state     = S_I_CK;
                end else begin
                    n_state = S_POST;
                end
            end
            S_I_CK: begin
                if (i_sts.end_eq) begin
                    w_cmd.wr_en   = 1'b1;
                    w_cmd.wsel    = ffha_pkg::W_MERGE;
                    w_cmd.res_set = 1'b1;
                    n_state       = S_M_RD;
                end else if (i_sts.start_gt) begin
                    n_state = S_POST;
                end else begin
                    w_cmd.idx_op = ffha_pkg::I_INC;
                    n_state      = S_I_RD;
                end
            end
            S_M_RD: begin
                if (i_sts.idx1_lt_cnt) begin
                    w_cmd.rd_en = 1'b1;
                    w_cmd.rsel  = ffha_pkg::R_NEXT;
                    n_state     = S_M_CK;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_M_CK: begin
                if (i_sts.chain_eq) begin
                    w_cmd.wr_en  = 1'b1;
                    w_cmd.wsel   = ffha_pkg::W_CHAIN;
                    w_cmd.idx_op = ffha_pkg::I_INC;
                    n_state      = S_R_RD;
                end else begin
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_POST: begin
                w_cmd.res_set = 1'b1;
                if (i_sts.idx_lt_cnt && i_sts.top_eq) begin
                    w_cmd.wr_en = 1'b1;
                    w_cmd.wsel  = ffha_pkg::W_TOP;
                    n_done      = 1'b1;
                    n_state     = S_IDLE;
                end else if (i_sts.full) begin
                    w_cmd.res_code = ffha_pkg::ST_FULL;
                    n_done         = 1'b1;
                    n_state        = S_IDLE;
                end else begin
                    w_cmd.pos_save = 1'b1;
                    w_cmd.idx_op   = ffha_pkg::I_CNT;
                    n_state        = S_U_RD;
                end
            end
            S_U_RD: begin
                if (i_sts.idx_gt_pos) begin
                    w_cmd.rd_en = 1'b1;
                    w_cmd.rsel  = ffha_pkg::R_PREV;
                    n_state     = S_U_CK;
                end else begin
                    w_cmd.wr_en   = 1'b1;
                    w_cmd.wsel    = ffha_pkg::W_NEW;
                    w_cmd.cnt_inc = 1'b1;
                    n_done        = 1'b1;
                    n_state       = S_IDLE;
                end
            end
            S_U_CK: begin
                w_cmd.wr_en  = 1'b1;
                w_cmd.wsel   = ffha_pkg::W_MOVE;
                w_cmd.idx_op = ffha_pkg::I_DEC;
                n_state      = S_U_RD;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    assign o_cmd  = w_cmd;
    assign o_busy = (r_state != S_IDLE);
    assign o_done = r_done;

    `ASSERT_CLK(a_done_idle, !r_done || (r_state == S_IDLE), "word shown while busy")
    `ASSERT_NEXT(a_start_prep, i_start && !o_busy, r_state == S_PREP,
                 "accepted request did not start")
    `ASSERT_CLK(a_rw_excl, !(w_cmd.wr_en && w_cmd.rd_en), "table read and write together")
endmodule

### dv/first_fit_hole_allocator_test.sv
// Self-checking testbench for the first-fit hole allocator: random and directed requests
module first_fit_hole_allocator_test;
    timeunit 1ns;
    timeprecision 1ps;
    import ffha_pkg::*;

    localparam int NHOLES = MAX_HOLES_DEF;
    localparam int LIMIT_CYCLES = 4000000;
    localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    t_req i_req = '0;
    logic o_done;
    t_rsp o_rsp;
    logic i_cfg_valid = 1'b0;
    logic o_cfg_ready;
    logic [ADDR_W-1:0] i_cfg_data = '0;

    first_fit_hole_allocator #(.MAX_HOLES(NHOLES)) dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy), .i_req(i_req),
        .o_done(o_done), .o_rsp(o_rsp), .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready), .i_cfg_data(i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    logic [ADDR_W-1:0] hstart[NHOLES];
    logic [LEN_W-1:0]  hlen[NHOLES];
    int                hcount;
    logic [ADDR_W-1:0] offset_m;

    t_req   req_q[$];
    t_rsp   rsp_q[$];
    int     errors = 0;
    int     gap = 0;
    int     cycles = 0;
    logic   hold_tx = 1'b1;
    logic   cfg_req = 1'b0;
    logic [ADDR_W-1:0] cfg_val;

    function automatic void drop_hole(int i);
        for (int k = i; k + 1 < hcount; k++) begin
            hstart[k] = hstart[k+1];
            hlen[k] = hlen[k+1];
        end
        if (hcount > 0) hcount--;
    endfunction

    function automatic logic [LEN_W-1:0] sat_len(logic [LEN_W-1:0] a, logic [LEN_W-1:0] b);
        logic [LEN_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[LEN_W] ? LEN_MAX : s[LEN_W-1:0];
    endfunction

    function automatic t_status merge_range(logic [ADDR_W-1:0] s, logic [LEN_W-1:0] len);
        int i;
        if (len == 0) return ST_OK;
        for (i = 0; i < hcount; i++) begin
            if (hstart[i] + ADDR_W'(hlen[i]) == s) begin
                hlen[i] = sat_len(hlen[i], len);
                if (i + 1 < hcount && hstart[i] + ADDR_W'(hlen[i]) == hstart[i+1]) begin
                    hlen[i] = sat_len(hlen[i], hlen[i+1]);
                    drop_hole(i + 1);
                end
                return ST_OK;
            end
            if (hstart[i] > s) break;
        end
        if (i < hcount && s + ADDR_W'(len) == hstart[i]) begin
            hstart[i] = s;
            hlen[i] = sat_len(hlen[i], len);
            return ST_OK;
        end
        if (hcount >= NHOLES) return ST_FULL;
        for (int k = hcount; k > i; k--) begin
            hstart[k] = hstart[k-1];
            hlen[k] = hlen[k-1];
        end
        hstart[i] = s;
        hlen[i] = len;
        hcount++;
        return ST_OK;
    endfunction

    function automatic t_rsp predict_grant(t_req r);
        t_rsp p;
        logic [LEN_W-1:0] need;
        p = '0;
        case (t_req_type'(r.req_type))
            REQ_ALLOC: begin
                if (r.req_size > SIZE_LIMIT) begin
                    p.status = ST_TOO_BIG;
                end else begin
                    need = (r.req_size + LEN_W'(ALIGN_BYTES + HEADER_BYTES))
                           & ~LEN_W'(ALIGN_BYTES - 1);
                    p.status = ST_NO_FIT;
                    for (int i = 0; i < hcount; i++) begin
                        if (hlen[i] >= need) begin
                            p.block_addr = hstart[i];
                            p.granted_size = need[GRANT_W-1:0];
                            hstart[i] += ADDR_W'(need);
                            hlen[i] -= need;
                            if (hlen[i] == 0) drop_hole(i);
                            p.status = ST_OK;
                            break;
                        end
                    end
                end
            end
            REQ_FREE: p.status = merge_range(r.req_addr - ADDR_W'(HEADER_BYTES), r.req_size);
            REQ_ADD:  p.status = merge_range(r.req_addr + offset_m, r.req_size);
            default:  p.status = ST_OK;
        endcase
        return p;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(10, 150);
    endfunction

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (start && !busy) begin
                rsp_q.push_back(predict_grant(i_req));
            end
            if (start && busy) begin
                // hold
            end else if (gap > 0) begin
                start <= 1'b0;
                gap <= gap - 1;
            end else if (!hold_tx && req_q.size() > 0) begin
                i_req <= req_q.pop_front();
                start <= 1'b1;
                gap <= pick_gap();
            end else begin
                start <= 1'b0;
            end
        end
    end

    // config writer
    always @(posedge i_clk) begin
        if (i_cfg_valid && o_cfg_ready) begin
            offset_m = i_cfg_data;
            i_cfg_valid <= 1'b0;
            cfg_req <= 1'b0;
        end else if (cfg_req && !i_cfg_valid) begin
            i_cfg_valid <= 1'b1;
            i_cfg_data <= cfg_val;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rsp e;
        cycles <= cycles + 1;
        if (i_rst_n && o_done) begin
            if (rsp_q.size() == 0) begin
                $error("unexpected result word status=%0d", o_rsp.status);
                errors++;
            end else begin
                e = rsp_q.pop_front();
                if (o_rsp.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, o_rsp.status); errors++;
                end
                if (o_rsp.block_addr !== e.block_addr) begin
                    $error("block_addr exp %h got %h", e.block_addr, o_rsp.block_addr);
                    errors++;
                end
                if (o_rsp.granted_size !== e.granted_size) begin
                    $error("granted_size exp %h got %h", e.granted_size, o_rsp.granted_size);
                    errors++;
                end
            end
        end
        if (cycles > LIMIT_CYCLES) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    function automatic t_req mk(t_req_type t, logic [ADDR_W-1:0] a, logic [LEN_W-1:0] s);
        t_req r;
        r.req_type = t;
        r.req_addr = a;
        r.req_size = s;
        return r;
    endfunction

    task automatic drain();
        hold_tx = 1'b0;
        wait (req_q.size() == 0 && !start && gap == 0);
        wait (rsp_q.size() == 0 && !busy);
        repeat (4 * NHOLES + 20) @(posedge i_clk);
        hold_tx = 1'b1;
    endtask

    task automatic write_offset(logic [ADDR_W-1:0] v);
        cfg_val = v;
        cfg_req = 1'b1;
        wait (!cfg_req);
        @(posedge i_clk);
    endtask

    task automatic fill_random(int n, logic [ADDR_W-1:0] base);
        int r;
        logic [LEN_W-1:0] sz;
        for (int j = 0; j < n; j++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                sz = (r < 3) ? LEN_W'({$urandom, $urandom}) : LEN_W'($urandom_range(0, 600));
                req_q.push_back(mk(REQ_ALLOC, {$urandom, $urandom}, sz));
            end else if (r < 75) begin
                req_q.push_back(mk(REQ_FREE,
                    base + ADDR_W'($urandom_range(0, 4000) * 8), LEN_W'($urandom_range(0, 64) * 8)));
            end else if (r < 95) begin
                req_q.push_back(mk(REQ_ADD, base + ADDR_W'($urandom_range(0, 8000) * 8),
                    LEN_W'($urandom_range(0, 128) * 8)));
            end else if (r < 97) begin
                req_q.push_back(mk(REQ_ADD, {$urandom, $urandom}, LEN_W'({$urandom, $urandom})));
            end else begin
                req_q.push_back(mk(REQ_NONE, {$urandom, $urandom}, LEN_W'({$urandom, $urandom})));
            end
        end
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        offset_m = '0;

        req_q.push_back(mk(REQ_ALLOC, '0, '0));
        req_q.push_back(mk(REQ_ADD, 64'h1000, 48'h100));
        req_q.push_back(mk(REQ_ADD, 64'h1100, 48'h100));
        req_q.push_back(mk(REQ_ADD, 64'h0f00, 48'h100));
        req_q.push_back(mk(REQ_ADD, 64'h2000, 48'h0));
        req_q.push_back(mk(REQ_ALLOC, '0, 48'h0));
        req_q.push_back(mk(REQ_ALLOC, '0, SIZE_LIMIT));
        req_q.push_back(mk(REQ_ALLOC, '0, SIZE_LIMIT + 1));
        req_q.push_back(mk(REQ_ALLOC, '1, LEN_MAX));
        req_q.push_back(mk(REQ_ALLOC, '0, 48'h2e0));
        req_q.push_back(mk(REQ_FREE, 64'h0f08, 48'h100));
        req_q.push_back(mk(REQ_FREE, 64'h1108, 48'h100));
        req_q.push_back(mk(REQ_FREE, 64'h1008, 48'h100));
        req_q.push_back(mk(REQ_FREE, 64'h0, 48'h10));
        req_q.push_back(mk(REQ_ADD, 64'hFFFF_FFFF_FFFF_FFF0, 48'h20));
        req_q.push_back(mk(REQ_ADD, 64'h8000_0000, LEN_MAX));
        req_q.push_back(mk(REQ_ADD, 64'h7FFF_FFF0, 48'h10));
        req_q.push_back(mk(REQ_NONE, '1, LEN_MAX));
        req_q.push_back(mk(REQ_ALLOC, '0, 48'h7));
        drain();

        for (int j = 0; j < NHOLES + 4; j++)
            req_q.push_back(mk(REQ_ADD, 64'h10_0000 + ADDR_W'(j) * 64'h40, 48'h10));
        for (int j = 0; j < 8; j++)
            req_q.push_back(mk(REQ_ALLOC, '0, 48'h8));
        drain();

        write_offset('1);
        req_q.push_back(mk(REQ_ADD, 64'h100, 48'h40));
        req_q.push_back(mk(REQ_ALLOC, '0, 48'h8));
        drain();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: write_offset('0);
                1: write_offset(64'h8000_0000_0000_0000);
                2: write_offset({$urandom, $urandom});
                default: write_offset(64'(p) << 32);
            endcase
            fill_random(290, 64'(p) << 32);
            drain();
        end

        if (errors == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
